// ===== hdl/tsps_pkg.sv =====
// ----------------------------------------------------------------------------
// tsps_pkg - shared types and constants for the temperature sensor sequencer
// Operation, phase and bus action codes, config bytes and the item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tsps_pkg;

  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned WORD_W        = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

  localparam logic [7:0] CFG_NONE    = 8'h00;
  localparam logic [7:0] CFG_MEASURE = 8'h40;
  localparam logic [7:0] CFG_SLEEP   = 8'h60;
  localparam logic [7:0] ID_MASK     = 8'hF0;
  localparam logic [7:0] ID_VALUE    = 8'hC0;
  localparam logic [WORD_W-1:0] ERR_WORD = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_STEP = 2'd1,
    OP_INIT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_ENABLE = 3'd0,
    PH_WAIT   = 3'd1,
    PH_READ   = 3'd2,
    PH_SLEEP  = 3'd3,
    PH_IDLE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_WRITE_CFG = 3'd1,
    ACT_READ_STAT = 3'd2,
    ACT_READ_TEMP = 3'd3,
    ACT_ID_CHECK  = 3'd4
  } action_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       first_ok;
    logic       second_ok;
    logic [7:0] id_byte;
    logic [7:0] status_byte;
    logic [7:0] temp_high;
    logic [7:0] temp_low;
  } item_t;

  typedef struct packed {
    phase_t               phase;
    logic [TIMEOUT_W-1:0] remaining;
    logic                 done;
    logic                 init_good;
  } seq_state_t;

  typedef struct packed {
    action_t           bus_action;
    logic [7:0]        config_value;
    logic              publish;
    logic [WORD_W-1:0] published_value;
    logic              measure_done;
    logic [2:0]        phase_now;
    logic              sensor_ready;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/tsps_step.sv =====
// ----------------------------------------------------------------------------
// tsps_step - one sequencer step
// Combinational: item and current state in, next state and result item out.
// ----------------------------------------------------------------------------
`default_nettype none

module tsps_step (
  input  wire tsps_pkg::item_t             item,
  input  wire tsps_pkg::seq_state_t        st,
  input  wire [tsps_pkg::TIMEOUT_W-1:0]    timeout,
  output tsps_pkg::seq_state_t             st_nxt,
  output tsps_pkg::result_t                res
);

  logic                          restart;
  tsps_pkg::phase_t              ph_eff;
  logic                          id_ok;
  logic [11:0]                   mag;
  logic [15:0]                   prod;
  logic [11:0]                   tenths;
  logic [tsps_pkg::WORD_W-1:0]   temp_word;

  assign restart = (st.remaining == '0);
  assign ph_eff  = restart ? tsps_pkg::PH_ENABLE : st.phase;
  assign id_ok   = item.first_ok &&
                   ((item.id_byte & tsps_pkg::ID_MASK) == tsps_pkg::ID_VALUE);

  // magnitude in 1/16 degree, times ten, divided by sixteen
  assign mag       = {item.temp_high[6:0], item.temp_low[7:3]};
  assign prod      = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
  assign tenths    = prod[15:4];
  assign temp_word = item.temp_high[7] ? (16'd0 - {4'b0000, tenths})
                                       : {4'b0000, tenths};

  // next state
  always_comb begin
    st_nxt = st;
    case (tsps_pkg::op_t'(item.operation))
      tsps_pkg::OP_TICK: begin
        if (st.remaining != '0) begin
          st_nxt.remaining = st.remaining - 1'b1;
        end
      end
      tsps_pkg::OP_INIT: begin
        st_nxt.init_good = id_ok && item.second_ok;
      end
      tsps_pkg::OP_STEP: begin
        if (st.init_good) begin
          if (restart) begin
            st_nxt.done      = 1'b0;
            st_nxt.phase     = tsps_pkg::PH_ENABLE;
            st_nxt.remaining = timeout;
          end
          case (ph_eff)
            tsps_pkg::PH_ENABLE: begin
              if (item.first_ok) begin
                st_nxt.phase     = tsps_pkg::PH_WAIT;
                st_nxt.remaining = timeout;
              end
            end
            tsps_pkg::PH_WAIT: begin
              if (item.first_ok && !item.status_byte[7]) begin
                st_nxt.phase     = tsps_pkg::PH_READ;
                st_nxt.remaining = timeout;
              end
            end
            tsps_pkg::PH_READ: begin
              if (item.first_ok && item.second_ok) begin
                st_nxt.phase     = tsps_pkg::PH_SLEEP;
                st_nxt.remaining = timeout;
              end
            end
            tsps_pkg::PH_SLEEP: begin
              if (item.first_ok) begin
                st_nxt.done      = 1'b1;
                st_nxt.phase     = tsps_pkg::PH_IDLE;
                st_nxt.remaining = timeout;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // result item
  always_comb begin
    res.bus_action      = tsps_pkg::ACT_NONE;
    res.config_value    = tsps_pkg::CFG_NONE;
    res.publish         = 1'b0;
    res.published_value = '0;
    res.measure_done    = st_nxt.done;
    res.phase_now       = st_nxt.phase;
    res.sensor_ready    = st_nxt.init_good;
    case (tsps_pkg::op_t'(item.operation))
      tsps_pkg::OP_INIT: begin
        res.bus_action = tsps_pkg::ACT_ID_CHECK;
        if (id_ok) begin
          res.config_value = tsps_pkg::CFG_SLEEP;
        end
      end
      tsps_pkg::OP_STEP: begin
        if (!st.init_good) begin
          res.publish         = 1'b1;
          res.published_value = tsps_pkg::ERR_WORD;
        end else begin
          case (ph_eff)
            tsps_pkg::PH_ENABLE: begin
              res.bus_action   = tsps_pkg::ACT_WRITE_CFG;
              res.config_value = tsps_pkg::CFG_MEASURE;
              if (!item.first_ok) begin
                res.publish         = 1'b1;
                res.published_value = tsps_pkg::ERR_WORD;
              end
            end
            tsps_pkg::PH_WAIT: begin
              res.bus_action = tsps_pkg::ACT_READ_STAT;
            end
            tsps_pkg::PH_READ: begin
              res.bus_action = tsps_pkg::ACT_READ_TEMP;
              if (item.first_ok && item.second_ok) begin
                res.publish         = 1'b1;
                res.published_value = temp_word;
              end
            end
            tsps_pkg::PH_SLEEP: begin
              res.bus_action   = tsps_pkg::ACT_WRITE_CFG;
              res.config_value = tsps_pkg::CFG_SLEEP;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/temp_sensor_poll_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// temp_sensor_poll_sequencer_unit - polled temperature sensor sequencer
// Input register, one combinational step, result register; timeout register.
// ----------------------------------------------------------------------------
// Each input item is a millisecond tick, a step or an init together with the
// outcome of the bus transfers of that phase; each gives exactly one result
// item. The block takes one item per clock cycle while in_ready is high; an
// accepted item is held in the input register, then passes through the step
// logic into the result register. The sequencer state (phase, countdown,
// done and init flags) is updated in the same cycle the result is registered,
// so consecutive items see each other's effect in order. in_ready falls only
// when both the input and result registers hold items and out_ready is low.
// Write the timeout register through the cfg port (always ready) only while
// no item is in flight (not enforced by the block); it resets to 1000 ms.
`default_nettype none

module temp_sensor_poll_sequencer_unit #(
  parameter logic [tsps_pkg::TIMEOUT_W-1:0] TIMEOUT_RESET = tsps_pkg::TIMEOUT_RST
) (
  input  wire        clk,
  input  wire        rst_n,
  // configuration
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [15:0] cfg_timeout_ms,
  // input items
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  in_operation,
  input  wire        in_first_ok,
  input  wire        in_second_ok,
  input  wire [7:0]  in_id_byte,
  input  wire [7:0]  in_status_byte,
  input  wire [7:0]  in_temp_high,
  input  wire [7:0]  in_temp_low,
  // result items
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_bus_action,
  output logic [7:0] out_config_value,
  output logic       out_publish,
  output logic [15:0] out_published_value,
  output logic       out_measure_done,
  output logic [2:0] out_phase_now,
  output logic       out_sensor_ready
);

  logic [tsps_pkg::TIMEOUT_W-1:0] timeout_r;

  logic                 s1_valid_r;
  tsps_pkg::item_t      s1_item_r;
  logic                 out_valid_r;
  tsps_pkg::result_t    res_r;
  tsps_pkg::result_t    res_nxt;
  tsps_pkg::seq_state_t st_r;
  tsps_pkg::seq_state_t st_nxt;

  logic out_free;
  logic s1_move;
  logic in_take;

  // pipeline control: result register frees when empty or being taken
  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_r <= cfg_timeout_ms;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.operation   <= in_operation;
      s1_item_r.first_ok    <= in_first_ok;
      s1_item_r.second_ok   <= in_second_ok;
      s1_item_r.id_byte     <= in_id_byte;
      s1_item_r.status_byte <= in_status_byte;
      s1_item_r.temp_high   <= in_temp_high;
      s1_item_r.temp_low    <= in_temp_low;
    end
  end

  tsps_step u_step (
    .item    (s1_item_r),
    .st      (st_r),
    .timeout (timeout_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  // sequencer state advances with each item leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= tsps_pkg::PH_IDLE;
      st_r.remaining <= '0;
      st_r.done      <= 1'b0;
      st_r.init_good <= 1'b0;
    end else if (s1_move) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bus_action      = res_r.bus_action;
  assign out_config_value    = res_r.config_value;
  assign out_publish         = res_r.publish;
  assign out_published_value = res_r.published_value;
  assign out_measure_done    = res_r.measure_done;
  assign out_phase_now       = res_r.phase_now;
  assign out_sensor_ready    = res_r.sensor_ready;

  // no phase movement until init has passed
  a_phase_held: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.init_good |=> $stable(st_r.phase))
    else $error("phase moved without a good init");

  // the done flag is only seen while idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.done |-> (st_r.phase == tsps_pkg::PH_IDLE))
    else $error("done flag outside idle");

  // a config write carries the measure or sleep byte
  a_cfg_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.bus_action == tsps_pkg::ACT_WRITE_CFG)) |->
      ((res_r.config_value == tsps_pkg::CFG_MEASURE) ||
       (res_r.config_value == tsps_pkg::CFG_SLEEP)))
    else $error("bad config byte");

  // a temperature word is published only by a temperature read
  a_pub_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.publish &&
     (res_r.published_value != tsps_pkg::ERR_WORD)) |->
      (res_r.bus_action == tsps_pkg::ACT_READ_TEMP))
    else $error("publish outside temperature read");

endmodule

`default_nettype wire
